// ----- design/idsa_pkg.sv -----
// ----------------------------------------------------------------------------
// idsa_pkg: shared types and codes for the slot allocator
// Word formats, command and status codes, cell command and chain link types.
// ----------------------------------------------------------------------------
package idsa_pkg;

	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_FIND    = 2'd1;
	localparam logic [1:0] KIND_MARK    = 2'd2;
	localparam logic [1:0] KIND_CONFIRM = 2'd3;

	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_ALREADY = 3'd1;
	localparam logic [2:0] ST_INVALID = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_PERSIST = 3'd4;
	localparam logic [2:0] ST_OK      = 3'd5;
	localparam logic [2:0] ST_REJECT  = 3'd6;

	localparam int OCC_MAX = 63;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] dev_id;
		logic        persist_ok;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] endpoint;
		logic [5:0] occupied;
	} out_word_t;

	typedef struct packed {
		logic        look;
		logic [63:0] id;
		logic        claim;
		logic        mark;
		logic        clear;
	} cell_cmd_t;

	typedef struct packed {
		logic       hit_seen;
		logic       hit_pend;
		logic [7:0] hit_idx;
		logic       free_seen;
		logic [7:0] free_idx;
	} chain_t;

endpackage

// ----- design/idsa_cell.sv -----
// ----------------------------------------------------------------------------
// idsa_cell: one slot of the allocator table
// Holds one entry, compares it against the command id and passes the
// first-match and first-free selection on to the next cell.
// ----------------------------------------------------------------------------
module idsa_cell #(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  idsa_pkg::cell_cmd_t  cmd,
	input  idsa_pkg::chain_t     prev,
	output idsa_pkg::chain_t     next
);

	localparam logic [7:0] IDX_V = 8'(IDX);

	logic        used_q;
	logic        pend_q;
	logic [63:0] id_q;
	logic        match_s1;
	logic        free_s1;
	logic        hit_sel;
	logic        free_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s1 <= 1'b0;
			free_s1  <= 1'b0;
		end else if (cmd.look) begin
			match_s1 <= used_q && (id_q == cmd.id);
			free_s1  <= !used_q;
		end
	end

	assign hit_sel  = match_s1 && !prev.hit_seen;
	assign free_sel = free_s1 && !prev.free_seen;

	always_comb begin
		next           = prev;
		next.hit_seen  = prev.hit_seen || match_s1;
		next.free_seen = prev.free_seen || free_s1;
		if (hit_sel) begin
			next.hit_pend = pend_q;
			next.hit_idx  = IDX_V;
		end
		if (free_sel) begin
			next.free_idx = IDX_V;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (cmd.claim && free_sel) begin
			used_q <= 1'b1;
			pend_q <= 1'b0;
		end else if (cmd.mark && hit_sel) begin
			pend_q <= 1'b1;
		end else if (cmd.clear && hit_sel) begin
			used_q <= 1'b0;
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.claim && free_sel) begin
			id_q <= cmd.id;
		end
	end

`ifndef SYNTHESIS
	a_pend_used: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> used_q)
		else $error("pending slot is not in use");
	a_pend_from_used: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_q) |-> $past(used_q) && $past(cmd.mark))
		else $error("slot marked without being assigned");
	a_free_from_pend: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(used_q) |-> $past(pend_q) && $past(cmd.clear))
		else $error("slot freed without pending removal");
`endif

endmodule

// ----- design/id_to_endpoint_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// id_to_endpoint_slot_allocator: device id to endpoint slot table
// Flow: the accepted word is compared in the look state and selected in the
// pick state; a new word is taken only after the last result is registered,
// and a held result delays the select state until it is taken.
// Reset: table empty, endpoint_base 1, occupancy 0, no result pending.
// ----------------------------------------------------------------------------
module id_to_endpoint_slot_allocator #(
	parameter int SLOTS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  idsa_pkg::in_word_t    in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output idsa_pkg::out_word_t   out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_data
);

	localparam int OCW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOOK = 3'b010,
		S_PICK = 3'b100
	} state_t;

	state_t               state_q;
	idsa_pkg::in_word_t   cmd_q;
	logic [7:0]           base_q;
	logic [OCW-1:0]       cnt_q;
	logic [OCW-1:0]       cnt_next;
	logic                 out_valid_q;
	idsa_pkg::out_word_t  out_data_q;
	idsa_pkg::chain_t     link [SLOTS+1];
	idsa_pkg::chain_t     tail;
	idsa_pkg::cell_cmd_t  cell_cmd;
	idsa_pkg::out_word_t  res;
	logic                 commit;
	logic                 do_claim;
	logic                 do_mark;
	logic                 do_clear;
	logic                 hit_ok;
	logic [8:0]           cnt_ext;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_data;
		end
	end

	assign link[0] = '0;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		idsa_cell #(
			.IDX (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cell_cmd),
			.prev   (link[g]),
			.next   (link[g+1])
		);
	end

	assign tail   = link[SLOTS];
	assign commit = (state_q == S_PICK) && (!out_valid_q || !out_stall);
	assign hit_ok = tail.hit_seen && !tail.hit_pend;

	always_comb begin
		res.status   = idsa_pkg::ST_REJECT;
		res.endpoint = 8'd0;
		do_claim     = 1'b0;
		do_mark      = 1'b0;
		do_clear     = 1'b0;
		if (cmd_q.dev_id == 64'd0) begin
			res.status = idsa_pkg::ST_INVALID;
		end else begin
			case (cmd_q.kind)
				idsa_pkg::KIND_ALLOC: begin
					if (hit_ok) begin
						res.status   = idsa_pkg::ST_ALREADY;
						res.endpoint = base_q + tail.hit_idx;
					end else if (!tail.free_seen) begin
						res.status = idsa_pkg::ST_FULL;
					end else if (cmd_q.persist_ok) begin
						res.status   = idsa_pkg::ST_NEW;
						res.endpoint = base_q + tail.free_idx;
						do_claim     = 1'b1;
					end else begin
						res.status = idsa_pkg::ST_PERSIST;
					end
				end
				idsa_pkg::KIND_FIND: begin
					if (hit_ok) begin
						res.status   = idsa_pkg::ST_OK;
						res.endpoint = base_q + tail.hit_idx;
					end
				end
				idsa_pkg::KIND_MARK: begin
					if (hit_ok) begin
						if (cmd_q.persist_ok) begin
							res.status   = idsa_pkg::ST_OK;
							res.endpoint = base_q + tail.hit_idx;
							do_mark      = 1'b1;
						end else begin
							res.status = idsa_pkg::ST_PERSIST;
						end
					end
				end
				idsa_pkg::KIND_CONFIRM: begin
					if (tail.hit_seen && tail.hit_pend) begin
						if (cmd_q.persist_ok) begin
							res.status = idsa_pkg::ST_OK;
							do_clear   = 1'b1;
						end else begin
							res.status = idsa_pkg::ST_PERSIST;
						end
					end
				end
				default: begin
					res.status = idsa_pkg::ST_REJECT;
				end
			endcase
		end
		cnt_next = cnt_q + OCW'(do_claim) - OCW'(do_clear);
		cnt_ext  = 9'(cnt_next);
		if (cnt_ext > 9'(idsa_pkg::OCC_MAX)) begin
			res.occupied = 6'(idsa_pkg::OCC_MAX);
		end else begin
			res.occupied = cnt_ext[5:0];
		end
	end

	always_comb begin
		cell_cmd.look  = (state_q == S_LOOK);
		cell_cmd.id    = cmd_q.dev_id;
		cell_cmd.claim = commit && do_claim;
		cell_cmd.mark  = commit && do_mark;
		cell_cmd.clear = commit && do_clear;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				cnt_q       <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= SLOTS)
		else $error("occupancy count above table size");
	a_new_counts: assert property (@(posedge clk) disable iff (!arst_n)
		commit && do_claim |=> cnt_q == $past(cnt_q) + OCW'(1))
		else $error("claim did not raise occupancy");
	a_out_after_pick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_PICK))
		else $error("result word without a select cycle");
`endif

endmodule

// ----- sim/id_to_endpoint_slot_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// id_to_endpoint_slot_allocator_tb: slot allocator table check
// Drives allocate, find, mark and confirm words through the stall handshake,
// keeps a shadow of the slot table and endpoint base, and compares every
// result word in order. Covers zero ids, rollback, tombstones, a full table,
// endpoint wrap and several base settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module id_to_endpoint_slot_allocator_tb;

	localparam int SLOTS = 32;
	localparam int ID_POOL = 40;
	localparam int STALL_LIMIT = 2000;

	class slot_table_tracker;
		logic [7:0]           base;
		bit                   used [SLOTS];
		logic [63:0]          ids [SLOTS];
		bit                   pend [SLOTS];
		idsa_pkg::out_word_t  awaited[$];
		int                   errors;

		function new();
			base = 8'd1;
			errors = 0;
			for (int i = 0; i < SLOTS; i++) begin
				used[i] = 0;
				ids[i] = '0;
				pend[i] = 0;
			end
		endfunction

		function void load_base(logic [7:0] v);
			base = v;
		endfunction

		function int waiting();
			return awaited.size();
		endfunction

		function void note_command(idsa_pkg::in_word_t w);
			idsa_pkg::out_word_t r;
			int hit;
			int open_slot;
			int n;
			r.status = idsa_pkg::ST_REJECT;
			r.endpoint = '0;
			hit = -1;
			open_slot = -1;
			if (w.dev_id == '0) begin
				r.status = idsa_pkg::ST_INVALID;
			end else begin
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && used[i] && ids[i] == w.dev_id)
						hit = i;
				case (w.kind)
					idsa_pkg::KIND_ALLOC: begin
						if (hit >= 0 && !pend[hit]) begin
							r.status = idsa_pkg::ST_ALREADY;
							r.endpoint = base + 8'(hit);
						end else begin
							r.status = idsa_pkg::ST_FULL;
							for (int i = 0; i < SLOTS; i++)
								if (open_slot < 0 && !used[i])
									open_slot = i;
							if (open_slot >= 0) begin
								if (w.persist_ok) begin
									used[open_slot] = 1;
									ids[open_slot] = w.dev_id;
									pend[open_slot] = 0;
									r.status = idsa_pkg::ST_NEW;
									r.endpoint = base + 8'(open_slot);
								end else begin
									r.status = idsa_pkg::ST_PERSIST;
								end
							end
						end
					end
					idsa_pkg::KIND_FIND: begin
						if (hit >= 0 && !pend[hit]) begin
							r.status = idsa_pkg::ST_OK;
							r.endpoint = base + 8'(hit);
						end
					end
					idsa_pkg::KIND_MARK: begin
						if (hit >= 0 && !pend[hit]) begin
							if (w.persist_ok) begin
								pend[hit] = 1;
								r.status = idsa_pkg::ST_OK;
								r.endpoint = base + 8'(hit);
							end else begin
								r.status = idsa_pkg::ST_PERSIST;
							end
						end
					end
					default: begin
						if (hit >= 0 && pend[hit]) begin
							if (w.persist_ok) begin
								used[hit] = 0;
								ids[hit] = '0;
								pend[hit] = 0;
								r.status = idsa_pkg::ST_OK;
							end else begin
								r.status = idsa_pkg::ST_PERSIST;
							end
						end
					end
				endcase
			end
			n = 0;
			for (int i = 0; i < SLOTS; i++)
				if (used[i])
					n++;
			if (n > idsa_pkg::OCC_MAX)
				n = idsa_pkg::OCC_MAX;
			r.occupied = 6'(n);
			awaited.push_back(r);
		endfunction

		function void check_reply(idsa_pkg::out_word_t got);
			idsa_pkg::out_word_t want;
			if (awaited.size() == 0) begin
				$display("%0t: result with none outstanding: status %0d endpoint %0d occupied %0d",
					$time, got.status, got.endpoint, got.occupied);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.endpoint !== want.endpoint) begin
				$display("%0t: endpoint expected %0d actual %0d", $time, want.endpoint,
					got.endpoint);
				errors++;
			end
			if (got.occupied !== want.occupied) begin
				$display("%0t: occupied expected %0d actual %0d", $time, want.occupied,
					got.occupied);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	idsa_pkg::in_word_t   in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	idsa_pkg::out_word_t  out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [7:0]           cfg_data = '0;

	slot_table_tracker tracker = new();
	logic [63:0] id_pool [ID_POOL];
	bit          tx_idle = 0;
	bit          rx_idle = 0;
	int          hold_off_req = 0;
	int          stall_left = 0;
	int          quiet_cycles = 0;

	id_to_endpoint_slot_allocator #(.SLOTS(SLOTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			tracker.check_reply(out_data);
		if (in_valid && !in_stall)
			tracker.note_command(in_data);
		if (cfg_valid && cfg_ready)
			tracker.load_base(cfg_data);
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (hold_off_req != 0) begin
			out_stall <= 1'b1;
			stall_left <= 80;
			hold_off_req = 0;
		end else if (rx_idle && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_word(input idsa_pkg::in_word_t w);
		if (tx_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_cmd(input logic [1:0] kind, input logic [63:0] id, input logic ok);
		idsa_pkg::in_word_t w;
		w.kind = kind;
		w.dev_id = id;
		w.persist_ok = ok;
		send_word(w);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.waiting() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_base(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic idsa_pkg::in_word_t random_word();
		idsa_pkg::in_word_t w;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			w.kind = idsa_pkg::KIND_ALLOC;
		else if (pick < 55)
			w.kind = idsa_pkg::KIND_FIND;
		else if (pick < 77)
			w.kind = idsa_pkg::KIND_MARK;
		else
			w.kind = idsa_pkg::KIND_CONFIRM;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			w.dev_id = '0;
		else if (pick < 8)
			w.dev_id = {$urandom, $urandom};
		else
			w.dev_id = id_pool[$urandom_range(0, ID_POOL - 1)];
		w.persist_ok = ($urandom_range(0, 7) != 0);
		return w;
	endfunction

	task automatic run_random(input int count);
		repeat (count)
			send_word(random_word());
	endtask

	initial begin
		logic [63:0] id_a;
		logic [63:0] id_b;
		logic [63:0] id_c;
		for (int i = 0; i < ID_POOL; i++) begin
			id_pool[i] = {$urandom, $urandom};
			if (id_pool[i] == '0)
				id_pool[i] = 64'd1;
		end
		id_a = '1;
		id_b = 64'd1;
		id_c = id_pool[0];

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(idsa_pkg::KIND_ALLOC, '0, 1'b1);
		send_cmd(idsa_pkg::KIND_FIND, '0, 1'b0);
		send_cmd(idsa_pkg::KIND_MARK, '0, 1'b1);
		send_cmd(idsa_pkg::KIND_CONFIRM, '0, 1'b1);
		send_cmd(idsa_pkg::KIND_FIND, id_a, 1'b1);
		send_cmd(idsa_pkg::KIND_ALLOC, id_a, 1'b0);
		send_cmd(idsa_pkg::KIND_ALLOC, id_a, 1'b1);
		send_cmd(idsa_pkg::KIND_ALLOC, id_a, 1'b1);
		send_cmd(idsa_pkg::KIND_ALLOC, id_b, 1'b1);
		send_cmd(idsa_pkg::KIND_FIND, id_a, 1'b0);
		send_cmd(idsa_pkg::KIND_CONFIRM, id_a, 1'b1);
		send_cmd(idsa_pkg::KIND_MARK, id_a, 1'b0);
		send_cmd(idsa_pkg::KIND_MARK, id_a, 1'b1);
		send_cmd(idsa_pkg::KIND_FIND, id_a, 1'b1);
		send_cmd(idsa_pkg::KIND_MARK, id_a, 1'b1);
		send_cmd(idsa_pkg::KIND_ALLOC, id_a, 1'b1);
		send_cmd(idsa_pkg::KIND_CONFIRM, id_a, 1'b0);
		send_cmd(idsa_pkg::KIND_CONFIRM, id_a, 1'b1);
		send_cmd(idsa_pkg::KIND_CONFIRM, id_a, 1'b1);
		send_cmd(idsa_pkg::KIND_ALLOC, id_c, 1'b1);
		send_cmd(idsa_pkg::KIND_FIND, id_b, 1'b1);
		drain();

		write_base(8'd255);
		tx_idle = 1;
		rx_idle = 1;
		run_random(60);
		tx_idle = 0;
		hold_off_req = 1;
		run_random(30);
		tx_idle = 1;
		run_random(90);
		drain();

		write_base(8'd0);
		run_random(75);
		drain();
		run_random(75);
		drain();

		write_base(8'($urandom_range(2, 254)));
		run_random(120);
		drain();

		write_base(8'd224);
		tx_idle = 0;
		rx_idle = 0;
		run_random(130);
		drain();
		repeat (10) @(posedge clk);

		if (tracker.errors == 0 && tracker.waiting() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/idsa_pkg.sv
design/idsa_cell.sv
design/id_to_endpoint_slot_allocator.sv
sim/id_to_endpoint_slot_allocator_tb.sv
